// ===== hw/rtl/clre_pkg.sv =====
// ----------------------------------------------------------------------------
// clre_pkg
// Shared types and character codes for the console line receiver.
// ----------------------------------------------------------------------------
package clre_pkg;

	localparam int BYTE_W     = 8;
	localparam int LINE_LEN_W = 6;
	localparam int INDEX_W    = 6;
	localparam int ACTION_W   = 2;
	// compare width for read_index against the buffer depth (depth <= 256)
	localparam int RANGE_W    = 9;

	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

	typedef enum logic [ACTION_W-1:0] {
		ACT_RX       = 2'd0,
		ACT_TX_READY = 2'd1,
		ACT_READ     = 2'd2
	} action_t;

	typedef struct packed {
		logic [ACTION_W-1:0]   action;
		logic [BYTE_W-1:0]     rx_byte;
		logic [INDEX_W-1:0]    read_index;
	} in_item_t;

	typedef struct packed {
		logic                  tx_valid;
		logic [BYTE_W-1:0]     tx_byte;
		logic                  tx_active;
		logic                  line_ready;
		logic [LINE_LEN_W-1:0] line_length;
		logic [BYTE_W-1:0]     read_data;
		logic                  echo_dropped;
	} out_item_t;

	// echo request from the line buffer to the transmit FIFO
	typedef struct packed {
		logic              one;
		logic              crlf;
		logic [BYTE_W-1:0] data;
	} echo_req_t;

	// per-beat line buffer status, captured into the result stage
	typedef struct packed {
		logic                  line_ready;
		logic [LINE_LEN_W-1:0] line_length;
		logic                  read_sel;
	} line_res_t;

	// per-beat transmit status, captured into the result stage
	typedef struct packed {
		logic tx_valid;
		logic tx_lf;
		logic dropped;
	} tx_res_t;

endpackage

// ===== hw/rtl/clre_stream_if.sv =====
// ----------------------------------------------------------------------------
// clre_stream_if
// Valid/ready channel carrying one payload item per beat.
// ----------------------------------------------------------------------------
interface clre_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

// ===== hw/rtl/console_line_receiver_with_echo_fifo_top.sv =====
// ----------------------------------------------------------------------------
// console_line_receiver_with_echo_fifo_top
// Console command-line assembler with a transmit echo FIFO.
// ----------------------------------------------------------------------------
// Input channel req carries one action per beat: a received byte, a
// transmitter-ready strobe, or a read of one line buffer entry. Output
// channel rsp returns exactly one result per input beat, in order.
// An accepted beat lands in the input stage, is processed against the line
// buffer, the edit position and the echo FIFO once the output stage is free
// or draining, and its result is captured in the output stage; one beat per
// cycle is sustained while rsp is ready. The line buffer and the FIFO
// each use one memory access per beat, with registered read data.
// A terminator stores a zero byte, reports line_ready with the length and
// queues CR and LF; echo bytes that find the FIFO full are dropped and
// flagged in echo_dropped.
// Reset clears the edit position, the FIFO pointers and the busy flag; the
// memories are not cleared. When rsp stalls, the output stage holds, the
// input stage fills, and req.ready drops until rsp takes its beat.
// ----------------------------------------------------------------------------
module console_line_receiver_with_echo_fifo_top #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	clre_stream_if.sink          req,
	clre_stream_if.source        rsp
);

	logic                 valid_s1;
	clre_pkg::in_item_t   item_s1;
	logic                 valid_s2;
	clre_pkg::line_res_t  line_res_s2;
	clre_pkg::tx_res_t    tx_res_s2;

	logic                        fire;
	logic                        take;
	logic                        pop_req;
	clre_pkg::echo_req_t         echo;
	clre_pkg::line_res_t         line_res;
	clre_pkg::tx_res_t           tx_res;
	logic [clre_pkg::BYTE_W-1:0] line_byte;
	logic [clre_pkg::BYTE_W-1:0] fifo_byte;
	logic                        sending;
	clre_pkg::out_item_t         out_item;

	// advance the input stage when the output stage is free or being drained
	assign fire      = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || fire;
	assign take      = req.valid && req.ready;
	assign pop_req   = (item_s1.action == clre_pkg::ACT_TX_READY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= req.item;
		end
		if (fire) begin
			line_res_s2 <= line_res;
			tx_res_s2   <= tx_res;
		end
	end

	clre_line_buf #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.echo      (echo),
		.res       (line_res),
		.read_byte (line_byte)
	);

	clre_echo_fifo #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_echo_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.pop_req  (pop_req),
		.echo     (echo),
		.res      (tx_res),
		.mem_byte (fifo_byte),
		.sending  (sending)
	);

	always_comb begin
		out_item              = '0;
		out_item.tx_valid     = tx_res_s2.tx_valid;
		if (tx_res_s2.tx_valid) begin
			out_item.tx_byte = tx_res_s2.tx_lf ? clre_pkg::CH_LF : fifo_byte;
		end
		out_item.tx_active    = sending;
		out_item.line_ready   = line_res_s2.line_ready;
		out_item.line_length  = line_res_s2.line_length;
		if (line_res_s2.read_sel) begin
			out_item.read_data = line_byte;
		end
		out_item.echo_dropped = tx_res_s2.dropped;
	end

	assign rsp.valid = valid_s2;
	assign rsp.item  = out_item;

	a_stall_holds_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !rsp.ready |=> valid_s2 && $stable(line_res_s2) && $stable(tx_res_s2))
		else $error("result stage changed while stalled");

	a_no_fire_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !fire)
		else $error("processing fired without an item");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !rsp.ready |-> !req.ready)
		else $error("input accepted while both stages are full");

endmodule

// ===== hw/rtl/clre_line_buf.sv =====
// ----------------------------------------------------------------------------
// clre_line_buf
// Command line store and edit position; decodes received bytes into echoes.
// ----------------------------------------------------------------------------
module clre_line_buf #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 fire,
	input  clre_pkg::in_item_t                   item,
	output clre_pkg::echo_req_t                  echo,
	output clre_pkg::line_res_t                  res,
	output logic [clre_pkg::BYTE_W-1:0]          read_byte
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam logic [AW-1:0] POS_LAST = AW'(BUFFER_DEPTH - 1);

	logic [clre_pkg::BYTE_W-1:0] mem [BUFFER_DEPTH];
	logic [AW-1:0]               pos_q;
	logic [AW-1:0]               pos_d;
	logic                        wr_en;
	logic [clre_pkg::BYTE_W-1:0] wr_data;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic                        is_erase;
	logic                        is_term;
	logic                        in_range;
	logic [clre_pkg::BYTE_W-1:0] rd_q;

	assign is_erase = (item.rx_byte == clre_pkg::CH_BS) || (item.rx_byte == clre_pkg::CH_DEL);
	assign is_term  = (item.rx_byte == clre_pkg::CH_CR) || (item.rx_byte == clre_pkg::CH_LF);
	assign in_range = clre_pkg::RANGE_W'(item.read_index) < clre_pkg::RANGE_W'(BUFFER_DEPTH);
	assign rd_addr  = AW'(item.read_index);

	always_comb begin
		pos_d   = pos_q;
		wr_en   = 1'b0;
		wr_data = item.rx_byte;
		rd_en   = 1'b0;
		echo    = '0;
		res     = '0;
		echo.data = item.rx_byte;
		if (fire && (item.action == clre_pkg::ACT_RX)) begin
			priority if (is_erase) begin
				// erase at line start is ignored silently
				if (pos_q != '0) begin
					pos_d    = pos_q - AW'(1);
					echo.one = 1'b1;
				end
			end else if (is_term) begin
				wr_en           = 1'b1;
				wr_data         = clre_pkg::CH_NUL;
				res.line_ready  = 1'b1;
				res.line_length = clre_pkg::LINE_LEN_W'(pos_q);
				pos_d           = '0;
				echo.crlf       = 1'b1;
			end else begin
				// keep the last slot for the terminator
				if (pos_q < POS_LAST) begin
					wr_en    = 1'b1;
					pos_d    = pos_q + AW'(1);
					echo.one = 1'b1;
				end
			end
		end
		if (fire && (item.action == clre_pkg::ACT_READ)) begin
			rd_en        = in_range;
			res.read_sel = in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else begin
			pos_q <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[pos_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign read_byte = rd_q;

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_LAST)
		else $error("line position beyond last slot");

	a_term_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (item.action == clre_pkg::ACT_RX) && is_term |=> pos_q == '0)
		else $error("terminator did not reset line position");

endmodule

// ===== hw/rtl/clre_echo_fifo.sv =====
// ----------------------------------------------------------------------------
// clre_echo_fifo
// Transmit ring FIFO for echo bytes; a CR entry can carry a trailing LF.
// ----------------------------------------------------------------------------
module clre_echo_fifo #(
	parameter int BUFFER_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        pop_req,
	input  clre_pkg::echo_req_t         echo,
	output clre_pkg::tx_res_t           res,
	output logic [clre_pkg::BYTE_W-1:0] mem_byte,
	output logic                        sending
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int EW = clre_pkg::BYTE_W + 1;
	localparam logic [AW-1:0] PTR_LAST = AW'(BUFFER_DEPTH - 1);

	// entry: {lf follows in the next slot, byte}
	logic [EW-1:0] mem [BUFFER_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic          sending_q;
	logic          mem_pop_q;
	logic [EW-1:0] rd_q;

	logic [AW-1:0] wp1;
	logic [AW-1:0] wp2;
	logic [AW-1:0] rp1;
	logic          empty;
	logic          ok1;
	logic          ok2;
	logic          lf_due;
	logic          push;
	logic [EW-1:0] wr_data;
	logic          do_pop;
	logic          rd_en;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + AW'(1);
	endfunction

	assign wp1    = ptr_inc(wp_q);
	assign wp2    = ptr_inc(wp1);
	assign rp1    = ptr_inc(rp_q);
	assign empty  = (rp_q == wp_q);
	assign ok1    = (wp1 != rp_q);
	assign ok2    = ok1 && (wp2 != rp_q);
	// the slot after a flagged CR holds an LF that was never written to memory
	assign lf_due = mem_pop_q && rd_q[EW-1];

	assign push    = fire && (echo.one || echo.crlf) && ok1;
	assign wr_data = echo.crlf ? {ok2, clre_pkg::CH_CR} : {1'b0, echo.data};
	assign do_pop  = fire && pop_req && !empty;
	assign rd_en   = do_pop && !lf_due;

	always_comb begin
		res          = '0;
		res.tx_valid = do_pop;
		res.tx_lf    = do_pop && lf_due;
		res.dropped  = fire && ((echo.one && !ok1) || (echo.crlf && !ok2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			rp_q      <= '0;
			sending_q <= 1'b0;
			mem_pop_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q      <= (echo.crlf && ok2) ? wp2 : wp1;
				sending_q <= 1'b1;
			end
			if (fire && pop_req && empty) begin
				sending_q <= 1'b0;
			end
			if (do_pop) begin
				rp_q      <= rp1;
				mem_pop_q <= !lf_due;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rp_q];
		end
	end

	assign mem_byte = rd_q[clre_pkg::BYTE_W-1:0];
	assign sending  = sending_q;

	a_lf_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		lf_due |-> !empty)
		else $error("pending LF slot while FIFO is empty");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (echo.one || echo.crlf) |=> wp_q != rp_q)
		else $error("FIFO empty after an echo request");

	a_idle_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && pop_req && empty |=> !sending_q && $stable(rp_q))
		else $error("empty ready beat did not clear busy");

endmodule

// ===== test/console_line_receiver_with_echo_fifo_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_line_receiver_with_echo_fifo_top_test
// Drives received bytes, transmitter-ready strobes, line buffer reads and the
// unused action into the console line receiver. A local model of the line
// buffer and echo FIFO predicts every result, and each response beat is
// checked field by field in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module console_line_receiver_with_echo_fifo_top_test;

	localparam int DEPTH = 64;
	localparam int QUIET_LIMIT = 1000;
	localparam logic [clre_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	clre_stream_if #(.item_t(clre_pkg::in_item_t)) req_if ();
	clre_stream_if #(.item_t(clre_pkg::out_item_t)) rsp_if ();

	console_line_receiver_with_echo_fifo_top #(
		.BUFFER_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// model state
	logic [clre_pkg::BYTE_W-1:0] line_mem [DEPTH];
	bit                          line_written [DEPTH];
	logic [clre_pkg::BYTE_W-1:0] echo_mem [DEPTH];
	int                          line_pos;
	int                          echo_wr;
	int                          echo_rd;
	bit                          echo_busy;

	clre_pkg::out_item_t awaited_results [$];
	clre_pkg::out_item_t exp_r;
	int                  mismatch_count;
	int                  quiet_cycles;
	int                  stall_left;
	bit                  gaps_on;
	bit                  stalls_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit queue_echo(logic [clre_pkg::BYTE_W-1:0] b);
		int nxt;
		nxt = (echo_wr + 1) % DEPTH;
		if (nxt == echo_rd)
			return 1'b1;
		echo_mem[echo_wr] = b;
		echo_wr = nxt;
		echo_busy = 1'b1;
		return 1'b0;
	endfunction

	function automatic clre_pkg::out_item_t predict_console_result(clre_pkg::in_item_t it);
		clre_pkg::out_item_t r;
		r = '0;
		case (it.action)
			clre_pkg::ACT_RX: begin
				if (it.rx_byte == clre_pkg::CH_BS || it.rx_byte == clre_pkg::CH_DEL) begin
					if (line_pos > 0) begin
						line_pos--;
						r.echo_dropped = queue_echo(it.rx_byte);
					end
				end else if (it.rx_byte == clre_pkg::CH_CR ||
						it.rx_byte == clre_pkg::CH_LF) begin
					line_mem[line_pos] = clre_pkg::CH_NUL;
					line_written[line_pos] = 1'b1;
					r.line_ready = 1'b1;
					r.line_length = clre_pkg::LINE_LEN_W'(line_pos);
					line_pos = 0;
					// each half of CR LF gets its own try
					if (queue_echo(clre_pkg::CH_CR))
						r.echo_dropped = 1'b1;
					if (queue_echo(clre_pkg::CH_LF))
						r.echo_dropped = 1'b1;
				end else if (line_pos < DEPTH - 1) begin
					line_mem[line_pos] = it.rx_byte;
					line_written[line_pos] = 1'b1;
					line_pos++;
					r.echo_dropped = queue_echo(it.rx_byte);
				end
			end
			clre_pkg::ACT_TX_READY: begin
				if (echo_rd == echo_wr) begin
					echo_busy = 1'b0;
				end else begin
					r.tx_valid = 1'b1;
					r.tx_byte = echo_mem[echo_rd];
					echo_rd = (echo_rd + 1) % DEPTH;
				end
			end
			clre_pkg::ACT_READ: r.read_data = line_mem[it.read_index];
			default: ;
		endcase
		r.tx_active = echo_busy;
		return r;
	endfunction

	function automatic logic [clre_pkg::BYTE_W-1:0] random_text_byte();
		logic [clre_pkg::BYTE_W-1:0] b;
		do
			b = clre_pkg::BYTE_W'($urandom_range(0, 255));
		while (b == clre_pkg::CH_BS || b == clre_pkg::CH_DEL ||
			b == clre_pkg::CH_CR || b == clre_pkg::CH_LF);
		return b;
	endfunction

	// returns -1 when no line buffer entry has been written yet
	function automatic int pick_written_index();
		int start;
		start = $urandom_range(0, DEPTH - 1);
		for (int k = 0; k < DEPTH; k++)
			if (line_written[(start + k) % DEPTH])
				return (start + k) % DEPTH;
		return -1;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_item(input logic [clre_pkg::ACTION_W-1:0] act,
			input logic [clre_pkg::BYTE_W-1:0] rx,
			input logic [clre_pkg::INDEX_W-1:0] idx);
		clre_pkg::in_item_t it;
		it.action = act;
		it.rx_byte = rx;
		it.read_index = idx;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_if.item <= it;
		req_if.valid <= 1'b1;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		awaited_results.push_back(predict_console_result(it));
		@(negedge clk);
	endtask

	task automatic send_rx(input logic [clre_pkg::BYTE_W-1:0] b);
		send_item(clre_pkg::ACT_RX, b, clre_pkg::INDEX_W'($urandom_range(0, DEPTH - 1)));
	endtask

	task automatic send_tx_ready();
		send_item(clre_pkg::ACT_TX_READY, clre_pkg::BYTE_W'($urandom_range(0, 255)),
			clre_pkg::INDEX_W'($urandom_range(0, DEPTH - 1)));
	endtask

	task automatic send_read(input int idx);
		send_item(clre_pkg::ACT_READ, clre_pkg::BYTE_W'($urandom_range(0, 255)),
			clre_pkg::INDEX_W'(idx));
	endtask

	// pop until empty, then one more strobe to clear the busy flag
	task automatic drain_echo_queue();
		while (echo_rd != echo_wr)
			send_tx_ready();
		send_tx_ready();
	endtask

	task automatic test_idle_after_reset();
		send_tx_ready();
		send_item(ACT_UNUSED, 8'hFF, 6'h3F);
		send_rx(clre_pkg::CH_BS);
		send_rx(clre_pkg::CH_DEL);
	endtask

	task automatic test_edit_and_read();
		send_rx(8'h00);
		send_rx(8'hFF);
		send_rx(8'h41);
		send_rx(8'h80);
		send_rx(clre_pkg::CH_BS);
		send_rx(clre_pkg::CH_DEL);
		send_rx(8'h7E);
		send_item(ACT_UNUSED, 8'h00, 6'h00);
		send_read(0);
		send_read(2);
		send_rx(clre_pkg::CH_CR);
		send_read(3);
		send_rx(clre_pkg::CH_LF);
		drain_echo_queue();
	endtask

	task automatic test_line_and_fifo_full();
		// fill the line and the FIFO together, then keep typing past the end
		repeat (DEPTH + 2)
			send_rx(random_text_byte());
		send_rx(clre_pkg::CH_BS);
		send_rx(random_text_byte());
		send_rx(clre_pkg::CH_CR);
		send_read(DEPTH - 1);
		send_read(0);
		drain_echo_queue();
		// leave exactly one free slot for CR so that LF alone is dropped
		repeat (DEPTH - 2)
			send_rx(random_text_byte());
		send_rx(clre_pkg::CH_LF);
		send_read(DEPTH - 2);
		drain_echo_queue();
	endtask

	task automatic test_random_traffic(input int count);
		int left;
		int tx_weight;
		int run_len;
		int pick;
		int idx;
		left = count;
		while (left > 0) begin
			// vary how fast the transmitter drains so the FIFO fills at times
			case ($urandom_range(0, 2))
				0: tx_weight = 5;
				1: tx_weight = 25;
				default: tx_weight = 50;
			endcase
			run_len = $urandom_range(20, 120);
			for (int n = 0; n < run_len && left > 0; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < tx_weight) begin
					send_tx_ready();
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 60)
						send_rx(random_text_byte());
					else if (pick < 66)
						send_rx(clre_pkg::BYTE_W'($urandom_range(0, 255)));
					else if (pick < 76)
						send_rx($urandom_range(0, 1) ? clre_pkg::CH_BS : clre_pkg::CH_DEL);
					else if (pick < 83)
						send_rx($urandom_range(0, 1) ? clre_pkg::CH_CR : clre_pkg::CH_LF);
					else if (pick < 97) begin
						idx = pick_written_index();
						if (idx < 0)
							send_tx_ready();
						else
							send_read(idx);
					end else
						send_item(ACT_UNUSED, clre_pkg::BYTE_W'($urandom_range(0, 255)),
							clre_pkg::INDEX_W'($urandom_range(0, DEPTH - 1)));
				end
				left--;
			end
		end
	endtask

	task automatic check_field(input string name, input int expv, input int actv);
		if (expv != actv) begin
			$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, expv, actv);
			mismatch_count++;
		end
	endtask

	// response ready with random stall bursts
	initial begin
		rsp_if.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 4);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: actual %h", $time, rsp_if.item);
				mismatch_count++;
			end else begin
				exp_r = awaited_results.pop_front();
				check_field("tx_valid", int'(exp_r.tx_valid), int'(rsp_if.item.tx_valid));
				check_field("tx_byte", int'(exp_r.tx_byte), int'(rsp_if.item.tx_byte));
				check_field("tx_active", int'(exp_r.tx_active),
					int'(rsp_if.item.tx_active));
				check_field("line_ready", int'(exp_r.line_ready),
					int'(rsp_if.item.line_ready));
				check_field("line_length", int'(exp_r.line_length),
					int'(rsp_if.item.line_length));
				check_field("read_data", int'(exp_r.read_data),
					int'(rsp_if.item.read_data));
				check_field("echo_dropped", int'(exp_r.echo_dropped),
					int'(rsp_if.item.echo_dropped));
			end
		end
	end

	// end the run if neither channel moves a beat for too long
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("console_line_receiver_with_echo_fifo_top_test: done, errors");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.item = '0;
		mismatch_count = 0;
		line_pos = 0;
		echo_wr = 0;
		echo_rd = 0;
		echo_busy = 1'b0;
		for (int k = 0; k < DEPTH; k++) begin
			line_mem[k] = '0;
			line_written[k] = 1'b0;
			echo_mem[k] = '0;
		end
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_after_reset();
		test_edit_and_read();
		test_line_and_fifo_full();
		test_random_traffic(1000);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		test_random_traffic(200);

		req_if.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("console_line_receiver_with_echo_fifo_top_test: done, clean");
		else
			$display("console_line_receiver_with_echo_fifo_top_test: done, errors");
		$finish;
	end

endmodule
